/* hdl/gfw_pkg.sv */
// ----------------------------------------------------------------------------
// gfw_pkg: shared constants, types and glyph ROM
// Geometry of the two-panel page-organized framebuffer, command codes,
// memory request and response bundles, and the 5x8 font.
// ----------------------------------------------------------------------------
package gfw_pkg;

  // Display geometry
  localparam int PANEL_WIDTH    = 64;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
  localparam int PANEL_BYTES    = PANEL_WIDTH * PAGE_COUNT;
  localparam int STORE_BYTES    = 2 * PANEL_BYTES;
  localparam int ROW_BYTES      = 2 * PANEL_WIDTH;
  localparam int SCREEN_WIDTH   = 2 * PANEL_WIDTH;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int COL_W  = $clog2(PANEL_WIDTH);
  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  // rows of the bottom page that are on screen
  localparam int LAST_ROWS = DISPLAY_HEIGHT - 8 * (PAGE_COUNT - 1);
  localparam logic [7:0] LAST_PAGE_MASK = 8'((1 << LAST_ROWS) - 1);

  // Glyph walk: every column touches up to two pages
  localparam int GLYPH_COLS = 5;
  localparam int STEP_COUNT = 2 * GLYPH_COLS;
  localparam int STEP_W     = $clog2(STEP_COUNT);

  // Word field widths
  localparam int CMD_W  = 2;
  localparam int POSX_W = 9;
  localparam int POSY_W = 8;
  localparam int CODE_W = 8;
  localparam int IDX_W  = 10;
  localparam int BYTE_W = 8;

  // read index decode width, one spare bit for the range check
  localparam int DEC_W = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic valid;  // read data ready for the output register
    logic oob;    // index beyond the store
  } rd_rsp_t;

  // 5x8 font, column 0 in the low byte, bit 0 at the top.
  // Anything outside the table draws blank.
  function automatic logic [8*GLYPH_COLS-1:0] glyph_bits(input logic [CODE_W-1:0] code);
    logic [8*GLYPH_COLS-1:0] g;
    case (code)
      8'h21:   g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
      8'h25:   g = {8'h62, 8'h64, 8'h08, 8'h13, 8'h23};
      8'h2D:   g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      8'h2E:   g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
      8'h2F:   g = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
      8'h30:   g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      8'h31:   g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      8'h32:   g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      8'h33:   g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
      8'h34:   g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      8'h35:   g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      8'h36:   g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      8'h37:   g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      8'h38:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39:   g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
      8'h3A:   g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
      8'h41:   g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      8'h42:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
      8'h43:   g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h44:   g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
      8'h45:   g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
      8'h46:   g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
      8'h47:   g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
      8'h48:   g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      8'h49:   g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      8'h4B:   g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
      8'h4C:   g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
      8'h4D:   g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      8'h4E:   g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
      8'h4F:   g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h50:   g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
      8'h52:   g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
      8'h53:   g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
      8'h54:   g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      8'h55:   g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      8'h56:   g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      8'h57:   g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
      8'h58:   g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      8'h5A:   g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

/* hdl/gfw_ram.sv */
// ----------------------------------------------------------------------------
// gfw_ram: simple dual-port synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gfw_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/gfw_ctrl.sv */
// ----------------------------------------------------------------------------
// gfw_ctrl: command sequencer
// Clear sweep, glyph read-modify-write walk over five columns and two
// pages, and read index decode into a store address.
// ----------------------------------------------------------------------------
module gfw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gfw_pkg::CMD_W-1:0]     command_i,
  input  logic [gfw_pkg::POSX_W-1:0]    pos_x_i,
  input  logic [gfw_pkg::POSY_W-1:0]    pos_y_i,
  input  logic [gfw_pkg::CODE_W-1:0]    char_code_i,
  input  logic [gfw_pkg::IDX_W-1:0]     read_index_i,
  input  logic                          invert_i,
  input  logic                          out_free_i,
  input  logic [gfw_pkg::BYTE_W-1:0]    rd_data_i,
  output gfw_pkg::ram_req_t             ram_req_o,
  output gfw_pkg::rd_rsp_t              rd_rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_DRAIN,
    ST_READ
  } state_e;

  state_e                           state_q, state_d;
  logic [gfw_pkg::ADDR_W-1:0]       clr_cnt_q, clr_cnt_d;
  logic [gfw_pkg::STEP_W-1:0]       step_q, step_d;
  logic                             wr_pend_q, wr_pend_d;
  logic                             oob_q, oob_d;

  // draw word and pending write, payload only
  logic [gfw_pkg::POSX_W-1:0]       x0_q;
  logic [gfw_pkg::POSY_W-1:0]       y0_q;
  logic [gfw_pkg::CODE_W-1:0]       code_q;
  logic                             inv_q;
  logic [gfw_pkg::ADDR_W-1:0]       wr_addr_q;
  logic [7:0]                       wr_mask_q;
  logic [7:0]                       wr_bits_q;

  logic                             accept;

  // draw step datapath
  logic [gfw_pkg::STEP_W-2:0]       col_idx;
  logic                             half;
  logic signed [gfw_pkg::POSX_W:0]  x_s;
  logic [gfw_pkg::POSX_W-1:0]       x_u;
  logic                             x_ok;
  logic                             d_panel;
  logic [gfw_pkg::COL_W-1:0]        d_col;
  logic signed [gfw_pkg::POSY_W-3:0] page_s;
  logic [gfw_pkg::PAGE_W-1:0]       d_page;
  logic                             page_ok;
  logic [2:0]                       shift;
  logic [8*gfw_pkg::GLYPH_COLS-1:0] glyph;
  logic [7:0]                       g_col;
  logic [15:0]                      bits_w;
  logic [15:0]                      mask_w;
  logic [7:0]                       d_bits;
  logic [7:0]                       d_mask;
  logic [gfw_pkg::ADDR_W-1:0]       d_addr;
  logic                             op_ok;

  // read decode
  logic [gfw_pkg::DEC_W-1:0]        idx_w;
  logic [gfw_pkg::PAGE_W-1:0]       r_page;
  logic [gfw_pkg::DEC_W-1:0]        r_rest;
  logic                             r_panel;
  logic [gfw_pkg::COL_W-1:0]        r_col;
  logic                             r_oob;
  logic [gfw_pkg::ADDR_W-1:0]       r_addr;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // ---------------- draw step: column step/2, page half ----------------
  always_comb begin
    col_idx = step_q[gfw_pkg::STEP_W-1:1];
    half    = step_q[0];

    x_s  = $signed({x0_q[gfw_pkg::POSX_W-1], x0_q})
         + $signed({1'b0, (gfw_pkg::POSX_W)'(col_idx)});
    x_ok = (x_s >= 0) && (x_s < gfw_pkg::SCREEN_WIDTH);
    x_u  = x_s[gfw_pkg::POSX_W-1:0];
    d_panel = (x_u >= gfw_pkg::POSX_W'(gfw_pkg::PANEL_WIDTH));
    d_col   = d_panel ? gfw_pkg::COL_W'(x_u - gfw_pkg::POSX_W'(gfw_pkg::PANEL_WIDTH))
                      : gfw_pkg::COL_W'(x_u);

    shift   = y0_q[2:0];
    page_s  = $signed({y0_q[gfw_pkg::POSY_W-1], y0_q[gfw_pkg::POSY_W-1:3]})
            + $signed({5'b0, half});
    page_ok = (page_s >= 0) && (page_s < gfw_pkg::PAGE_COUNT) &&
              (!half || (shift != 3'd0));
    d_page  = page_s[gfw_pkg::PAGE_W-1:0];

    glyph  = gfw_pkg::glyph_bits(code_q);
    g_col  = glyph[8*col_idx +: 8] ^ {8{inv_q}};
    bits_w = {8'h00, g_col} << shift;
    mask_w = {8'h00, 8'hFF} << shift;
    d_bits = half ? bits_w[15:8] : bits_w[7:0];
    d_mask = half ? mask_w[15:8] : mask_w[7:0];
    if (d_page == gfw_pkg::PAGE_W'(gfw_pkg::PAGE_COUNT - 1)) begin
      d_mask = d_mask & gfw_pkg::LAST_PAGE_MASK;
    end

    d_addr = (d_panel ? gfw_pkg::ADDR_W'(gfw_pkg::PANEL_BYTES) : '0)
           + gfw_pkg::ADDR_W'(d_page) * gfw_pkg::ADDR_W'(gfw_pkg::PANEL_WIDTH)
           + gfw_pkg::ADDR_W'(d_col);

    op_ok = (state_q == ST_DRAW) && x_ok && page_ok;
  end

  // ---------------- read index: page, then panel, then column ----------------
  always_comb begin
    idx_w  = gfw_pkg::DEC_W'(read_index_i);
    r_page = '0;
    for (int k = 1; k < gfw_pkg::PAGE_COUNT; k++) begin
      if (idx_w >= gfw_pkg::DEC_W'(k * gfw_pkg::ROW_BYTES)) begin
        r_page = gfw_pkg::PAGE_W'(k);
      end
    end
    r_rest  = idx_w - gfw_pkg::DEC_W'(r_page) * gfw_pkg::DEC_W'(gfw_pkg::ROW_BYTES);
    r_panel = (r_rest >= gfw_pkg::DEC_W'(gfw_pkg::PANEL_WIDTH));
    r_col   = r_panel ? gfw_pkg::COL_W'(r_rest - gfw_pkg::DEC_W'(gfw_pkg::PANEL_WIDTH))
                      : gfw_pkg::COL_W'(r_rest);
    r_oob   = (idx_w >= gfw_pkg::DEC_W'(gfw_pkg::STORE_BYTES));
    r_addr  = (r_panel ? gfw_pkg::ADDR_W'(gfw_pkg::PANEL_BYTES) : '0)
            + gfw_pkg::ADDR_W'(r_page) * gfw_pkg::ADDR_W'(gfw_pkg::PANEL_WIDTH)
            + gfw_pkg::ADDR_W'(r_col);
  end

  // ---------------- memory requests ----------------
  always_comb begin
    ram_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        ram_req_o.rd_en   = accept && (command_i == gfw_pkg::CMD_READ) && !r_oob;
        ram_req_o.rd_addr = r_addr;
      end
      ST_DRAW: begin
        ram_req_o.rd_en   = op_ok;
        ram_req_o.rd_addr = d_addr;
      end
      default: ;
    endcase

    if (state_q == ST_CLEAR) begin
      ram_req_o.wr_en   = 1'b1;
      ram_req_o.wr_addr = clr_cnt_q;
      ram_req_o.wr_data = {8{invert_i}};
    end else if (wr_pend_q) begin
      // merge: one RMW in flight, addresses of a glyph walk never repeat
      ram_req_o.wr_en   = 1'b1;
      ram_req_o.wr_addr = wr_addr_q;
      ram_req_o.wr_data = (rd_data_i & ~wr_mask_q) | (wr_bits_q & wr_mask_q);
    end
  end

  assign rd_rsp_o.valid = (state_q == ST_READ);
  assign rd_rsp_o.oob   = oob_q;

  // ---------------- next state ----------------
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    step_d    = step_q;
    oob_d     = oob_q;
    wr_pend_d = op_ok;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            gfw_pkg::CMD_CLEAR: begin
              state_d   = ST_CLEAR;
              clr_cnt_d = '0;
            end
            gfw_pkg::CMD_DRAW: begin
              state_d = ST_DRAW;
              step_d  = '0;
            end
            gfw_pkg::CMD_READ: begin
              state_d = ST_READ;
              oob_d   = r_oob;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == gfw_pkg::ADDR_W'(gfw_pkg::STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_DRAW: begin
        step_d = step_q + 1'b1;
        if (step_q == gfw_pkg::STEP_W'(gfw_pkg::STEP_COUNT - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_IDLE;
      ST_READ: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      clr_cnt_q <= '0;
      step_q    <= '0;
      oob_q     <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      step_q    <= step_d;
      oob_q     <= oob_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (command_i == gfw_pkg::CMD_DRAW)) begin
      x0_q   <= pos_x_i;
      y0_q   <= pos_y_i;
      code_q <= char_code_i;
      inv_q  <= invert_i;
    end
    if (op_ok) begin
      wr_addr_q <= d_addr;
      wr_mask_q <= d_mask;
      wr_bits_q <= d_bits;
    end
  end

endmodule

/* hdl/glyph_framebuffer_writer.sv */
// ----------------------------------------------------------------------------
// glyph_framebuffer_writer: text overlay engine for a two-panel display
//
//   channel | handshake              | word
//   --------+------------------------+-----------------------------------------
//   in      | in_valid_i / in_stall_o | command, pos_x, pos_y, char_code, index
//   out     | out_valid_o/ out_stall_i| read_byte (complemented store byte)
//   cfg     | cfg_valid_i/ cfg_ready_o| invert_mode
//
// Clear: one store byte written per cycle over all STORE_BYTES bytes.
// Draw: ten read-modify-write steps through the single RAM read port,
//   then a drain state for the last write.
// Read: the word sits in the output register until taken, and a further
//   word is accepted meanwhile. Command 3 is accepted and ignored.
// Store contents after reset are undefined until cleared; no clearing pass.
// ----------------------------------------------------------------------------
module glyph_framebuffer_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gfw_pkg::CMD_W-1:0]  command_i,
  input  logic [gfw_pkg::POSX_W-1:0] pos_x_i,
  input  logic [gfw_pkg::POSY_W-1:0] pos_y_i,
  input  logic [gfw_pkg::CODE_W-1:0] char_code_i,
  input  logic [gfw_pkg::IDX_W-1:0]  read_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gfw_pkg::BYTE_W-1:0] read_byte_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_data_i
);

  gfw_pkg::ram_req_t           ram_req;
  gfw_pkg::rd_rsp_t            rd_rsp;
  logic [gfw_pkg::BYTE_W-1:0]  rd_data;
  logic                        invert_q;
  logic                        out_valid_q, out_valid_d;
  logic [gfw_pkg::BYTE_W-1:0]  out_byte_q;
  logic                        out_free;
  logic                        out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      invert_q <= cfg_data_i;
    end
  end

  gfw_ram #(
    .DEPTH (gfw_pkg::STORE_BYTES),
    .WIDTH (gfw_pkg::BYTE_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data)
  );

  gfw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .char_code_i  (char_code_i),
    .read_index_i (read_index_i),
    .invert_i     (invert_q),
    .out_free_i   (out_free),
    .rd_data_i    (rd_data),
    .ram_req_o    (ram_req),
    .rd_rsp_o     (rd_rsp)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = rd_rsp.valid && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= rd_rsp.oob ? {gfw_pkg::BYTE_W{1'b1}} : ~rd_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_byte_o = out_byte_q;

endmodule

/* hdl/gfw_checker.sv */
// ----------------------------------------------------------------------------
// gfw_port_checker: port-level properties of the framebuffer writer
// Watches the top level ports only; attached by bind.
// ----------------------------------------------------------------------------
module gfw_port_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [gfw_pkg::CMD_W-1:0]  command_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [gfw_pkg::BYTE_W-1:0] read_byte_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_byte_o))
    else $error("output word changed under stall");

  // a clear keeps the input side busy for its sweep
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i == gfw_pkg::CMD_CLEAR) |=> in_stall_o)
    else $error("clear did not hold off the input");

  // a read into an empty output register shows its word once the read state has loaded it
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i == gfw_pkg::CMD_READ) && !out_valid_o
    |-> ##2 out_valid_o)
    else $error("read word missing");

  // a word appears only while a read is being finished
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without a read");

endmodule

bind glyph_framebuffer_writer gfw_port_checker u_gfw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_byte_o (read_byte_o)
);

/* dv/gfw_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gfw_checker: scoreboard for the glyph framebuffer writer
// Watches the command, result and config channels, keeps a mirror of the
// framebuffer and the invert mode, and checks every read byte in order.
// ----------------------------------------------------------------------------
module gfw_checker
  import gfw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [POSX_W-1:0] pos_x_i,
  input  logic [POSY_W-1:0] pos_y_i,
  input  logic [CODE_W-1:0] char_code_i,
  input  logic [IDX_W-1:0]  read_index_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [BYTE_W-1:0] read_byte_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       reads_checked_o,
  output int unsigned       draws_o,
  output int unsigned       clears_o
);

  localparam int REPORT_LIMIT = 10;

  // font columns, leftmost column in the top byte, bit 0 is the top row
  logic [8*GLYPH_COLS-1:0] font_rom [256];
  logic [BYTE_W-1:0]       frame_mirror [STORE_BYTES];
  logic                    invert_q;
  logic [BYTE_W-1:0]       expected_bytes [$];
  logic [BYTE_W-1:0]       want;
  int unsigned             fails;
  int unsigned             reads_checked;
  int unsigned             draws;
  int unsigned             clears;

  initial begin
    foreach (font_rom[i]) font_rom[i] = '0;
    font_rom[8'h21] = 40'h00_00_5F_00_00;
    font_rom[8'h25] = 40'h23_13_08_64_62;
    font_rom[8'h2D] = 40'h08_08_08_08_08;
    font_rom[8'h2E] = 40'h00_60_60_00_00;
    font_rom[8'h2F] = 40'h20_10_08_04_02;
    font_rom[8'h30] = 40'h3E_51_49_45_3E;
    font_rom[8'h31] = 40'h00_42_7F_40_00;
    font_rom[8'h32] = 40'h42_61_51_49_46;
    font_rom[8'h33] = 40'h21_41_45_4B_31;
    font_rom[8'h34] = 40'h18_14_12_7F_10;
    font_rom[8'h35] = 40'h27_45_45_45_39;
    font_rom[8'h36] = 40'h3C_4A_49_49_30;
    font_rom[8'h37] = 40'h01_71_09_05_03;
    font_rom[8'h38] = 40'h36_49_49_49_36;
    font_rom[8'h39] = 40'h06_49_49_29_1E;
    font_rom[8'h3A] = 40'h00_36_36_00_00;
    font_rom[8'h41] = 40'h7E_11_11_11_7E;
    font_rom[8'h42] = 40'h7F_49_49_49_36;
    font_rom[8'h43] = 40'h3E_41_41_41_22;
    font_rom[8'h44] = 40'h7F_41_41_22_1C;
    font_rom[8'h45] = 40'h7F_49_49_49_41;
    font_rom[8'h46] = 40'h7F_09_09_09_01;
    font_rom[8'h47] = 40'h3E_41_49_49_7A;
    font_rom[8'h48] = 40'h7F_08_08_08_7F;
    font_rom[8'h49] = 40'h00_41_7F_41_00;
    font_rom[8'h4B] = 40'h7F_08_14_22_41;
    font_rom[8'h4C] = 40'h7F_40_40_40_40;
    font_rom[8'h4D] = 40'h7F_02_0C_02_7F;
    font_rom[8'h4E] = 40'h7F_04_08_10_7F;
    font_rom[8'h4F] = 40'h3E_41_41_41_3E;
    font_rom[8'h50] = 40'h7F_09_09_09_06;
    font_rom[8'h52] = 40'h7F_09_19_29_46;
    font_rom[8'h53] = 40'h46_49_49_49_31;
    font_rom[8'h54] = 40'h01_01_7F_01_01;
    font_rom[8'h55] = 40'h3F_40_40_40_3F;
    font_rom[8'h56] = 40'h1F_20_40_20_1F;
    font_rom[8'h57] = 40'h3F_40_38_40_3F;
    font_rom[8'h58] = 40'h63_14_08_14_63;
    font_rom[8'h5A] = 40'h61_51_49_45_43;
  end

  // every on-screen pixel of the 5x8 cell is written, lit or not
  function automatic void mirror_draw(input int x0, input int y0,
                                      input logic [CODE_W-1:0] code);
    int                x;
    int                y;
    int                addr;
    logic [BYTE_W-1:0] column;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      x = x0 + c;
      if (x < 0 || x >= SCREEN_WIDTH) continue;
      column = font_rom[code][8*GLYPH_COLS-1-8*c -: 8];
      for (int r = 0; r < 8; r++) begin
        y = y0 + r;
        if (y < 0 || y >= DISPLAY_HEIGHT) continue;
        addr = (x / PANEL_WIDTH) * PANEL_BYTES + (y / 8) * PANEL_WIDTH + x % PANEL_WIDTH;
        frame_mirror[addr][y % 8] = column[r] ^ invert_q;
      end
    end
  endfunction

  // send order: page, then panel, then column
  function automatic logic [BYTE_W-1:0] mirror_read(input logic [IDX_W-1:0] idx);
    int page;
    int slot;
    int addr;
    if (idx >= STORE_BYTES) return 8'hFF;
    page = idx / ROW_BYTES;
    slot = idx % ROW_BYTES;
    addr = (slot / PANEL_WIDTH) * PANEL_BYTES + page * PANEL_WIDTH + slot % PANEL_WIDTH;
    return ~frame_mirror[addr];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q = 1'b0;
      expected_bytes.delete();
    end else begin
      // result side first: a word accepted at this edge cannot answer yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("[%0t] unexpected read_byte %02h, nothing pending", $realtime,
                     read_byte_i);
        end else begin
          want = expected_bytes.pop_front();
          reads_checked++;
          if (read_byte_i !== want) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $display("[%0t] read_byte mismatch: expected %02h actual %02h", $realtime,
                       want, read_byte_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          CMD_CLEAR: begin
            foreach (frame_mirror[a]) frame_mirror[a] = invert_q ? 8'hFF : 8'h00;
            clears++;
          end
          CMD_DRAW: begin
            mirror_draw($signed(pos_x_i), $signed(pos_y_i), char_code_i);
            draws++;
          end
          CMD_READ: expected_bytes.push_back(mirror_read(read_index_i));
          default: ;
        endcase
      end
      if (cfg_valid_i && cfg_ready_i) invert_q = cfg_data_i;
    end
    fail_count_o    <= fails;
    pending_o       <= expected_bytes.size();
    reads_checked_o <= reads_checked;
    draws_o         <= draws;
    clears_o        <= clears;
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for glyph_framebuffer_writer
// Drives clear, draw, read and ignored command words through directed corner
// cases and random text layouts under four idling phases, toggling invert
// mode between phases; gfw_checker predicts and compares every read byte.
// ----------------------------------------------------------------------------
module tb_top;
  import gfw_pkg::*;

  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = STORE_BYTES + 64;  // a clear is the longest job
  localparam int PHASE_WORDS   = 450;
  localparam int PHASES        = 4;

  logic              clk          = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid     = 1'b0;
  logic [CMD_W-1:0]  command      = CMD_CLEAR;
  logic [POSX_W-1:0] pos_x        = '0;
  logic [POSY_W-1:0] pos_y        = '0;
  logic [CODE_W-1:0] char_code    = '0;
  logic [IDX_W-1:0]  read_index   = '0;
  logic              out_stall    = 1'b0;
  logic              cfg_valid    = 1'b0;
  logic              cfg_data     = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [BYTE_W-1:0] read_byte;
  logic              cfg_ready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned reads_checked;
  int unsigned draws;
  int unsigned clears;
  int unsigned cycle_count = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct  = 0;
  int          last_x = 0;
  int          last_y = 0;

  glyph_framebuffer_writer u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (command),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .char_code_i  (char_code),
    .read_index_i (read_index),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_byte_o  (read_byte),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  gfw_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .command_i       (command),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .char_code_i     (char_code),
    .read_index_i    (read_index),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .read_byte_i     (read_byte),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .reads_checked_o (reads_checked),
    .draws_o         (draws),
    .clears_o        (clears)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // one word; payload holds while stalled, valid only drops for idle gaps
  task automatic send_word(input logic [CMD_W-1:0] cmd, input int x, input int y,
                           input int code, input int idx);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    pos_x      <= POSX_W'(x);
    pos_y      <= POSY_W'(y);
    char_code  <= CODE_W'(code);
    read_index <= IDX_W'(idx);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_draw(input int x, input int y, input int code);
    send_word(CMD_DRAW, x, y, code, $urandom_range(1023));
    last_x = x;
    last_y = y;
  endtask

  task automatic put_read(input int idx);
    send_word(CMD_READ, $urandom_range(511), $urandom_range(255), $urandom_range(255), idx);
  endtask

  // hold off the sender until every read byte is back and the last job is done
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_invert(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly on-screen text and reads around it; the rest is noise
  task automatic send_random_word(inout int unsigned counted);
    int pick;
    int x;
    int y;
    int code;
    pick = $urandom_range(99);
    if (pick < 2) begin
      send_word(CMD_CLEAR, $urandom_range(511), $urandom_range(255), $urandom_range(255),
                $urandom_range(1023));
    end else if (pick < 5) begin
      send_word(CMD_IGNORED, $urandom_range(511), $urandom_range(255), $urandom_range(255),
                $urandom_range(1023));
      return;
    end else if (pick < 50) begin
      if ($urandom_range(99) < 80) begin
        x = $urandom_range(SCREEN_WIDTH + 3) - 4;
        y = $urandom_range(DISPLAY_HEIGHT + 6) - 7;
      end else begin
        x = $urandom_range(511) - 256;
        y = $urandom_range(255) - 128;
      end
      code = ($urandom_range(99) < 75) ? $urandom_range(8'h5A, 8'h20) : $urandom_range(255);
      put_draw(x, y, code);
    end else begin
      x = last_x + $urandom_range(GLYPH_COLS - 1);
      y = last_y + $urandom_range(7);
      if ($urandom_range(99) < 60 && x >= 0 && x < SCREEN_WIDTH && y >= 0 &&
          y < DISPLAY_HEIGHT)
        put_read((y / 8) * ROW_BYTES + x);
      else
        put_read($urandom_range(1023));
    end
    counted++;
  endtask

  initial begin
    int unsigned counted;
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed: store must be cleared before anything is read
    write_invert(1'b0);
    send_word(CMD_CLEAR, 0, 0, 0, 0);
    put_draw(0, 0, 8'h41);
    put_draw(62, 4, 8'h30);       // straddles both panels and two pages
    put_draw(123, 60, 8'h5A);     // bottom-right corner, rows clipped
    put_draw(-2, -3, 8'h25);      // clipped on the left and top
    put_draw(10, 10, 8'h00);      // below space
    put_draw(20, 20, 8'hFF);      // above 'Z'
    put_draw(30, 30, 8'h22);      // in range, no glyph defined
    put_draw(-256, -128, 8'h21);  // fully off screen
    put_draw(255, 127, 8'h57);
    put_draw(126, 56, 8'h4D);     // right edge clip
    send_word(CMD_IGNORED, 5, 5, 8'h41, 0);
    put_read(0);
    put_read(1023);
    put_read(1);
    put_read(62);
    put_read(64);
    put_read(ROW_BYTES + 65);
    put_read(7 * ROW_BYTES + 123);
    settle();
    write_invert(1'b1);
    send_word(CMD_CLEAR, 0, 0, 0, 0);
    put_draw(40, 24, 8'h38);
    put_read(3 * ROW_BYTES + 41);
    put_read(0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_invert(p % 2 == 1);
      case (p)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 59; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin sender_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      counted = 0;
      while (counted < PHASE_WORDS) send_random_word(counted);
    end
    settle();

    $display("Covered %0d draws, %0d clears and %0d checked read bytes", draws, clears,
             reads_checked);
    $display("over %0d idling phases with invert mode both off and on", PHASES);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
hdl/gfw_pkg.sv
hdl/gfw_ram.sv
hdl/gfw_ctrl.sv
hdl/glyph_framebuffer_writer.sv
hdl/gfw_checker.sv
dv/gfw_checker.sv
dv/tb_top.sv
